// ----- design/tga_rle_pkg.sv -----
// ----------------------------------------------------------------------------
// tga_rle_pkg
// Shared types and constants for the run-length truecolor line decoder.
// ----------------------------------------------------------------------------
package tga_rle_pkg;

  localparam int FIFO_DEPTH_DEF = 4;

  localparam logic [15:0] WIDTH_RST  = 16'd1;
  localparam logic [5:0]  DEPTH_RST  = 6'd24;
  localparam logic [6:0]  COUNT_MASK = 7'h7F;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH = 3'd0,
    REG_COMPRESSED  = 3'd1,
    REG_PIXEL_DEPTH = 3'd2,
    REG_ALPHA_BITS  = 3'd3,
    REG_ORIENTATION = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] image_width;
    logic        compressed;
    logic [5:0]  pixel_depth;
    logic [3:0]  alpha_bits;
    logic [1:0]  orientation;
  } cfg_t;

  // one decoded pixel request handed from front to back
  typedef struct packed {
    logic [31:0] pixel_bytes;
    logic [15:0] column;
    logic [7:0]  run_length;
    logic        line_end;
  } entry_t;

endpackage

// ----- design/tga_rle_front.sv -----
// ----------------------------------------------------------------------------
// tga_rle_front
// Byte intake: packet headers, pixel assembly, column and run bookkeeping.
// ----------------------------------------------------------------------------
module tga_rle_front (
  input  logic                clk,
  input  logic                rst,
  input  tga_rle_pkg::cfg_t   cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          data_byte,
  input  logic                q_full,
  output logic                q_push,
  output tga_rle_pkg::entry_t q_data
);
  import tga_rle_pkg::*;

  logic [15:0] pixel_counter, pixel_counter_next;
  logic [7:0]  packet_remaining, packet_remaining_next;
  logic        packet_is_run, packet_is_run_next;
  logic [1:0]  byte_index, byte_index_next;
  logic [31:0] pixel_bytes, pixel_bytes_next;

  logic        accept, is_header, complete, pos_over, drop, ends;
  logic [15:0] w, pos, left, col;
  logic [1:0]  bpp_m1;
  logic [31:0] shifted, assembled;
  logic [7:0]  run_raw, run;
  logic [16:0] pos_sum;

  always_comb begin
    w = (cfg.image_width == 16'd0) ? 16'd1 : cfg.image_width;
    if (cfg.pixel_depth == 6'd0) begin
      bpp_m1 = 2'd0;
    end else if (cfg.pixel_depth > 6'd32) begin
      bpp_m1 = 2'd3;
    end else begin
      bpp_m1 = 2'((cfg.pixel_depth - 6'd1) >> 3);
    end
  end

  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign is_header = cfg.compressed && (packet_remaining == 8'd0);

  always_comb begin
    unique case (byte_index)
      2'd0:    shifted = {24'd0, data_byte};
      2'd1:    shifted = {16'd0, data_byte, 8'd0};
      2'd2:    shifted = {8'd0, data_byte, 16'd0};
      default: shifted = {data_byte, 24'd0};
    endcase
  end

  assign assembled = ((byte_index == 2'd0) ? 32'd0 : pixel_bytes) | shifted;
  assign complete  = !is_header && (byte_index >= bpp_m1);

  always_comb begin
    run_raw  = (cfg.compressed && packet_is_run) ? packet_remaining : 8'd1;
    pos_over = pixel_counter >= w;
    pos      = (!cfg.compressed && pos_over) ? 16'd0 : pixel_counter;
    left     = w - pos;
    run      = ({8'd0, run_raw} > left) ? left[7:0] : run_raw;
    col      = cfg.orientation[0] ? (w - 16'd1 - pos) : pos;
    pos_sum  = {1'b0, pos} + {9'd0, run};
    ends     = pos_sum >= {1'b0, w};
    drop     = cfg.compressed && pos_over;
  end

  always_comb begin
    pixel_counter_next    = pixel_counter;
    packet_remaining_next = packet_remaining;
    packet_is_run_next    = packet_is_run;
    byte_index_next       = byte_index;
    pixel_bytes_next      = pixel_bytes;
    if (accept) begin
      if (is_header) begin
        packet_is_run_next    = data_byte[7];
        packet_remaining_next = {1'b0, data_byte[6:0] & COUNT_MASK} + 8'd1;
        byte_index_next       = 2'd0;
        if (pos_over) begin
          pixel_counter_next = 16'd0;
        end
      end else begin
        pixel_bytes_next = assembled;
        if (!complete) begin
          byte_index_next = byte_index + 2'd1;
        end else begin
          byte_index_next = 2'd0;
          if (cfg.compressed) begin
            packet_remaining_next = packet_is_run ? 8'd0 : (packet_remaining - 8'd1);
          end
          if (!drop) begin
            pixel_counter_next = (!cfg.compressed && ends) ? 16'd0 : pos_sum[15:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_counter    <= '0;
      packet_remaining <= '0;
      packet_is_run    <= 1'b0;
      byte_index       <= '0;
    end else begin
      pixel_counter    <= pixel_counter_next;
      packet_remaining <= packet_remaining_next;
      packet_is_run    <= packet_is_run_next;
      byte_index       <= byte_index_next;
    end
  end

  always_ff @(posedge clk) begin
    pixel_bytes <= pixel_bytes_next;
  end

  assign q_push              = accept && complete && !drop;
  assign q_data.pixel_bytes  = assembled;
  assign q_data.column       = col;
  assign q_data.run_length   = run;
  assign q_data.line_end     = ends;

endmodule

// ----- design/tga_rle_fifo.sv -----
// ----------------------------------------------------------------------------
// tga_rle_fifo
// Short request queue between the byte front end and the color back end.
// ----------------------------------------------------------------------------
module tga_rle_fifo #(
  parameter int DEPTH = tga_rle_pkg::FIFO_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tga_rle_pkg::entry_t wr_data,
  input  logic                pop,
  output tga_rle_pkg::entry_t rd_data,
  output logic                full,
  output logic                empty
);
  import tga_rle_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  entry_t        mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full    = count == CW'(DEPTH);
  assign empty   = count == '0;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue pop while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + CW'(1))
    else $error("queue count did not follow push");

endmodule

// ----- design/tga_rle_back.sv -----
// ----------------------------------------------------------------------------
// tga_rle_back
// Color conversion (premultiply, 555 expand, passthrough) and output register.
// ----------------------------------------------------------------------------
module tga_rle_back (
  input  logic                clk,
  input  logic                rst,
  input  tga_rle_pkg::cfg_t   cfg,
  input  logic                q_empty,
  input  tga_rle_pkg::entry_t q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         column,
  output logic [7:0]          run_length,
  output logic [7:0]          red,
  output logic [7:0]          green,
  output logic [7:0]          blue,
  output logic                line_end
);
  import tga_rle_pkg::*;

  logic       load;
  logic [7:0] b0, b1, b2, b3;
  logic [7:0] r_c, g_c, b_c;

  function automatic logic [7:0] premul(input logic [7:0] c, input logic [7:0] a);
    logic [15:0] t;
    logic [16:0] s;
    t = c * a + 16'd128;
    s = {1'b0, t} + {9'd0, t[15:8]};
    return s[15:8];
  endfunction

  assign b0 = q_data.pixel_bytes[7:0];
  assign b1 = q_data.pixel_bytes[15:8];
  assign b2 = q_data.pixel_bytes[23:16];
  assign b3 = q_data.pixel_bytes[31:24];

  always_comb begin
    r_c = 8'd0;
    g_c = 8'd0;
    b_c = 8'd0;
    if (cfg.pixel_depth == 6'd32 && cfg.alpha_bits != 4'd0) begin
      r_c = premul(b2, b3);
      g_c = premul(b1, b3);
      b_c = premul(b0, b3);
    end else if (cfg.pixel_depth == 6'd32 || cfg.pixel_depth == 6'd24) begin
      r_c = b2;
      g_c = b1;
      b_c = b0;
    end else if (cfg.pixel_depth == 6'd16 || cfg.pixel_depth == 6'd15) begin
      // 1:5:5:5 word, low byte first
      b_c = {b0[4:0], 3'd0};
      g_c = {b1[1:0], b0[7:5], 3'd0};
      r_c = {b1[6:2], 3'd0};
    end
  end

  assign load  = !out_valid || !out_stall;
  assign q_pop = load && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      column     <= q_data.column;
      run_length <= q_data.run_length;
      red        <= r_c;
      green      <= g_c;
      blue       <= b_c;
      line_end   <= q_data.line_end;
    end
  end

endmodule

// ----- design/tga_rle_line_decoder_top.sv -----
// ----------------------------------------------------------------------------
// tga_rle_line_decoder_top
// Run-length truecolor line decoder: bytes in, colored column runs out.
// ----------------------------------------------------------------------------
// A completed pixel passes through the request queue, then the output register.
// Throughput: one byte per cycle; the front stalls only when the
//   FIFO_DEPTH-entry request queue between front and back is full.
// Reset (rst, synchronous): configuration registers return to their defaults, decode
//   state expects a header (compressed) at column zero, queue and output empty.
module tga_rle_line_decoder_top #(
  parameter int FIFO_DEPTH = tga_rle_pkg::FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] column,
  output logic [7:0]  run_length,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic        line_end
);
  import tga_rle_pkg::*;

  cfg_t   cfg;
  entry_t push_data, head_data;
  logic   q_push, q_pop, q_full, q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width <= WIDTH_RST;
      cfg.compressed  <= 1'b0;
      cfg.pixel_depth <= DEPTH_RST;
      cfg.alpha_bits  <= 4'd0;
      cfg.orientation <= 2'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH: cfg.image_width <= cfg_data;
        REG_COMPRESSED:  cfg.compressed  <= cfg_data[0];
        REG_PIXEL_DEPTH: cfg.pixel_depth <= cfg_data[5:0];
        REG_ALPHA_BITS:  cfg.alpha_bits  <= cfg_data[3:0];
        REG_ORIENTATION: cfg.orientation <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  tga_rle_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (push_data)
  );

  tga_rle_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (push_data),
    .pop     (q_pop),
    .rd_data (head_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  tga_rle_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_empty    (q_empty),
    .q_data     (head_data),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .column     (column),
    .run_length (run_length),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .line_end   (line_end)
  );

endmodule
